FILE: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Field widths, operation codes, character codes and the request and result
// records passed between the top level and the engine.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [1:0] OP_PUT_CUR = 2'd0;
    localparam logic [1:0] OP_PUT_POS = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_ERROR   = 8'd69;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    localparam logic [2:0] ADDR_DEFAULT_ATTR = 3'd0;
    localparam logic [2:0] ADDR_ERROR_ATTR   = 3'd4;

    localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

    typedef struct packed {
        logic [7:0] target_row;
        logic [7:0] target_col;
        logic [7:0] attribute;
        logic [7:0] char_code;
        logic [1:0] operation;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_attr;
        logic [7:0] read_char;
        logic       position_error;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } res_t;

endpackage

FILE: design/tcw_engine.sv
// ----------------------------------------------------------------------------
// tcw_engine: cell store, cursor and sequencer
// Runs one request at a time; scroll, clear and the post-reset wipe sweep
// the cell store one entry per cycle through a shared address counter.
// ----------------------------------------------------------------------------
module tcw_engine #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [7:0]    default_attr,
    input  logic [7:0]    error_attr,
    input  logic          in_valid,
    output logic          in_ready,
    input  tcw_pkg::cmd_t in_cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output tcw_pkg::res_t res
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW0  = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_MAX    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX    = ROW_W'(ROWS - 1);
    localparam logic [8:0]        COL_LIM    = 9'(COLUMNS);
    localparam logic [8:0]        ROW_LIM    = 9'(ROWS);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_ADDR   = 4'd2;
    localparam logic [3:0] ST_EXEC   = 4'd3;
    localparam logic [3:0] ST_RDWAIT = 4'd4;
    localparam logic [3:0] ST_SCROLL = 4'd5;
    localparam logic [3:0] ST_SDRAIN = 4'd6;
    localparam logic [3:0] ST_BLANK  = 4'd7;
    localparam logic [3:0] ST_CLEAR  = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    logic [15:0]       cell_mem [CELL_COUNT];
    logic [15:0]       rd_data_reg;

    logic [3:0]        state_reg;
    tcw_pkg::cmd_t     cmd_reg;
    logic              off_grid_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [COL_W-1:0]  wcol_reg;
    logic [ROW_W-1:0]  wrow_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ADDR_W-1:0] scan_reg;
    logic              cp_valid_reg;
    logic [ADDR_W-1:0] cp_dst_reg;
    logic              err_reg;
    logic [7:0]        rch_reg;
    logic [7:0]        rattr_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [15:0]       mem_wd;
    logic [ADDR_W-1:0] mem_ra;

    logic              in_off_grid;
    logic              is_put;
    logic              is_newline;
    logic              wrap;
    logic              scan_last;
    logic [7:0]        put_attr;

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    assign in_off_grid = ({1'b0, in_cmd.target_col} >= COL_LIM) ||
                         ({1'b0, in_cmd.target_row} >= ROW_LIM);
    assign is_put      = (cmd_reg.operation == tcw_pkg::OP_PUT_CUR) ||
                         ((cmd_reg.operation == tcw_pkg::OP_PUT_POS) && !off_grid_reg);
    assign is_newline  = (cmd_reg.char_code == tcw_pkg::CHAR_NEWLINE);
    assign wrap        = is_newline || (wcol_reg == COL_MAX);
    assign scan_last   = (scan_reg == LAST_CELL);
    assign put_attr    = (cmd_reg.attribute == 8'd0) ? default_attr : cmd_reg.attribute;

    assign res.cursor_col     = 7'(cur_col_reg);
    assign res.cursor_row     = 5'(cur_row_reg);
    assign res.position_error = err_reg;
    assign res.read_char      = rch_reg;
    assign res.read_attr      = rattr_reg;

    // single write port, single registered read port
    always_comb begin
        mem_we = 1'b0;
        mem_wa = scan_reg;
        mem_wd = 16'd0;
        mem_ra = scan_reg;
        unique case (state_reg)
            ST_INIT, ST_BLANK: begin
                mem_we = 1'b1;
            end
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = {default_attr, tcw_pkg::CHAR_SPACE};
            end
            ST_EXEC: begin
                mem_ra = addr_reg;
                if (is_put && !is_newline) begin
                    mem_we = 1'b1;
                    mem_wa = addr_reg;
                    mem_wd = {put_attr, cmd_reg.char_code};
                end else if ((cmd_reg.operation == tcw_pkg::OP_PUT_POS) && off_grid_reg) begin
                    mem_we = 1'b1;
                    mem_wa = LAST_CELL;
                    mem_wd = {error_attr, tcw_pkg::CHAR_ERROR};
                end
            end
            ST_SCROLL, ST_SDRAIN: begin
                mem_we = cp_valid_reg;
                mem_wa = cp_dst_reg;
                mem_wd = rd_data_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= cell_mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            scan_reg     <= '0;
            cp_valid_reg <= 1'b0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_INIT: begin
                    if (scan_last) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        scan_reg <= scan_reg + ADDR_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (in_valid) begin
                        cmd_reg      <= in_cmd;
                        off_grid_reg <= in_off_grid;
                        err_reg      <= 1'b0;
                        rch_reg      <= 8'd0;
                        rattr_reg    <= 8'd0;
                        state_reg    <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    if (cmd_reg.operation == tcw_pkg::OP_PUT_CUR) begin
                        wcol_reg <= cur_col_reg;
                        wrow_reg <= cur_row_reg;
                        addr_reg <= ADDR_W'(cur_row_reg * COLUMNS + cur_col_reg);
                    end else begin
                        wcol_reg <= COL_W'(cmd_reg.target_col);
                        wrow_reg <= ROW_W'(cmd_reg.target_row);
                        addr_reg <= ADDR_W'(cmd_reg.target_row * COLUMNS +
                                            cmd_reg.target_col);
                    end
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    unique case (cmd_reg.operation)
                        tcw_pkg::OP_PUT_CUR, tcw_pkg::OP_PUT_POS: begin
                            if (!is_put) begin
                                err_reg   <= 1'b1;
                                state_reg <= ST_DONE;
                            end else if (wrap && (wrow_reg == ROW_MAX)) begin
                                cur_col_reg <= '0;
                                cur_row_reg <= ROW_MAX;
                                scan_reg    <= ROW_STRIDE;
                                state_reg   <= ST_SCROLL;
                            end else if (wrap) begin
                                cur_col_reg <= '0;
                                cur_row_reg <= wrow_reg + ROW_W'(1);
                                state_reg   <= ST_DONE;
                            end else begin
                                cur_col_reg <= wcol_reg + COL_W'(1);
                                cur_row_reg <= wrow_reg;
                                state_reg   <= ST_DONE;
                            end
                        end
                        tcw_pkg::OP_READ: begin
                            if (off_grid_reg) begin
                                err_reg   <= 1'b1;
                                state_reg <= ST_DONE;
                            end else begin
                                state_reg <= ST_RDWAIT;
                            end
                        end
                        default: begin
                            cur_col_reg <= '0;
                            cur_row_reg <= '0;
                            scan_reg    <= '0;
                            state_reg   <= ST_CLEAR;
                        end
                    endcase
                end
                ST_RDWAIT: begin
                    rch_reg   <= rd_data_reg[7:0];
                    rattr_reg <= rd_data_reg[15:8];
                    state_reg <= ST_DONE;
                end
                ST_SCROLL: begin
                    cp_valid_reg <= 1'b1;
                    cp_dst_reg   <= scan_reg - ROW_STRIDE;
                    if (scan_last) begin
                        state_reg <= ST_SDRAIN;
                    end else begin
                        scan_reg <= scan_reg + ADDR_W'(1);
                    end
                end
                ST_SDRAIN: begin
                    cp_valid_reg <= 1'b0;
                    scan_reg     <= LAST_ROW0;
                    state_reg    <= ST_BLANK;
                end
                ST_BLANK, ST_CLEAR: begin
                    if (scan_last) begin
                        state_reg <= ST_DONE;
                    end else begin
                        scan_reg <= scan_reg + ADDR_W'(1);
                    end
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core: text-mode console with cursor and cell store
// Put, put at position, read and clear requests on a stream port; default
// and error attributes on an APB register port.
// ----------------------------------------------------------------------------
// A put passes the ST_ADDR, ST_EXEC and ST_DONE states, a read also ST_RDWAIT,
// before the output register raises m_tvalid. Scroll and clear add sweeps of
// the cell store, one entry per cycle.
// One request at a time: a new request is taken only once the engine has
// handed its result on to the output register; s_tready is low while a
// request is in work. After reset the cell store is wiped before the
// first request is taken; registers reset to 15 and 244.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], char_code[9:2], attribute[17:10], target_col[25:18],
    // target_row[33:26], zero pad
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cursor_col[6:0], cursor_row[11:7], position_error[12], read_char[20:13],
    // read_attr[28:21], zero pad
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]    default_attr_reg;
    logic [7:0]    error_attr_reg;
    logic          m_tvalid_reg;
    tcw_pkg::res_t m_res_reg;
    tcw_pkg::cmd_t in_cmd;
    tcw_pkg::res_t res;
    logic          res_valid;
    logic          res_ready;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_attr_reg <= tcw_pkg::DEFAULT_ATTR_RST;
            error_attr_reg   <= tcw_pkg::ERROR_ATTR_RST;
        end else if (cfg_write) begin
            unique case (paddr)
                tcw_pkg::ADDR_DEFAULT_ATTR: default_attr_reg <= pwdata[7:0];
                tcw_pkg::ADDR_ERROR_ATTR:   error_attr_reg   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            tcw_pkg::ADDR_DEFAULT_ATTR: prdata = {24'd0, default_attr_reg};
            tcw_pkg::ADDR_ERROR_ATTR:   prdata = {24'd0, error_attr_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign in_cmd = tcw_pkg::cmd_t'(s_tdata[33:0]);

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .default_attr (default_attr_reg),
        .error_attr   (error_attr_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_cmd       (in_cmd),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
            if (res_valid) begin
                m_res_reg <= res;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, m_res_reg};

endmodule
